### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Bodies are empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/cear_pkg.sv
// ----------------------------------------------------------------------------
// cear_pkg
// Shared types, constants and the quarter-wave sine table of the rotator.
// ----------------------------------------------------------------------------
package cear_pkg;

    // coordinate fixed point: fraction bits of every stored coordinate
    localparam int COORD_FRAC_BITS = 12;

    // fraction bits of the sine table entries
    localparam int Q15_BITS = 15;

    // axis codes of the command word
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // reset position of camera and eye, wrapped to 32 bits
    localparam logic signed [31:0] CAM_X_RST = 32'sd0;
    localparam logic signed [31:0] CAM_Y_RST = -(32'sd1000 <<< COORD_FRAC_BITS);
    localparam logic signed [31:0] CAM_Z_RST =  (32'sd2500 <<< COORD_FRAC_BITS);
    localparam logic signed [31:0] EYE_X_RST = -(32'sd300 <<< COORD_FRAC_BITS);
    localparam logic signed [31:0] EYE_Y_RST = -(32'sd300 <<< COORD_FRAC_BITS);
    localparam logic signed [31:0] EYE_Z_RST = -(32'sd1500 <<< COORD_FRAC_BITS);

    // degree constants
    localparam logic [8:0] DEG_90   = 9'd90;
    localparam logic [8:0] DEG_180  = 9'd180;
    localparam logic [8:0] DEG_270  = 9'd270;
    localparam logic [8:0] DEG_FULL = 9'd360;

    // angle reduction: bias is 182 turns, reciprocal is floor(2^16 / 45)
    localparam logic [16:0] ANGLE_BIAS = 17'd65520;
    localparam logic [10:0] RECIP_45   = 11'd1456;

    // round(sin(k deg) * 32768), k = 0..90
    localparam logic [15:0] SIN_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // table index and sign for one angle
    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } fold_t;

    // fold 0..359 degrees onto the first quadrant
    function automatic fold_t fold_quarter(input logic [8:0] d);
        fold_t f;
        if (d <= DEG_90) begin
            f.neg = 1'b0;
            f.idx = d[6:0];
        end else if (d <= DEG_180) begin
            f.neg = 1'b0;
            f.idx = 7'(DEG_180 - d);
        end else if (d <= DEG_270) begin
            f.neg = 1'b1;
            f.idx = 7'(d - DEG_180);
        end else begin
            f.neg = 1'b1;
            f.idx = 7'(DEG_FULL - d);
        end
        return f;
    endfunction

endpackage

### rtl/cear_angle_mod.sv
// ----------------------------------------------------------------------------
// cear_angle_mod
// Reduces a signed 16-bit degree count to 0..359 (Euclidean modulo 360).
// ----------------------------------------------------------------------------
module cear_angle_mod (
    input  logic signed [15:0] angle,
    output logic        [8:0]  deg
);

    logic [16:0] biased;
    logic [13:0] eighths;
    logic [24:0] prod;
    logic [8:0]  quot;
    logic [16:0] quot_360;
    logic [16:0] rem;
    logic [9:0]  rem10;

    // shift into positive range by a whole number of turns
    assign biased = {angle[15], angle} + cear_pkg::ANGLE_BIAS;

    // quotient by 360 = (biased / 8) / 45, estimate is exact or one low
    assign eighths  = biased[16:3];
    assign prod     = 25'(eighths) * 25'(cear_pkg::RECIP_45);
    assign quot     = prod[24:16];
    assign quot_360 = 17'(quot) * 17'(cear_pkg::DEG_FULL);
    assign rem      = biased - quot_360;
    assign rem10    = rem[9:0];

    // one correction step
    assign deg = (rem10 >= 10'(cear_pkg::DEG_FULL))
               ? 9'(rem10 - 10'(cear_pkg::DEG_FULL))
               : rem10[8:0];

endmodule

### rtl/cear_trig.sv
// ----------------------------------------------------------------------------
// cear_trig
// Sine and cosine of 0..359 degrees from the quarter-wave table, scaled to
// TRIG_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module cear_trig #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic        [8:0]                deg,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int MW = TRIG_FRAC_BITS + 1;

    logic [9:0]           cos_sum;
    logic [8:0]           cos_deg;
    cear_pkg::fold_t      s_fold;
    cear_pkg::fold_t      c_fold;
    logic [15:0]          s_mag;
    logic [15:0]          c_mag;
    logic [MW-1:0]        s_scl;
    logic [MW-1:0]        c_scl;
    logic signed [TW-1:0] s_pos;
    logic signed [TW-1:0] c_pos;

    // cosine is the sine a quarter turn on
    assign cos_sum = {1'b0, deg} + 10'(cear_pkg::DEG_90);
    assign cos_deg = (cos_sum >= 10'(cear_pkg::DEG_FULL))
                   ? 9'(cos_sum - 10'(cear_pkg::DEG_FULL))
                   : cos_sum[8:0];

    // table reads
    assign s_fold = cear_pkg::fold_quarter(deg);
    assign c_fold = cear_pkg::fold_quarter(cos_deg);
    assign s_mag  = cear_pkg::SIN_Q15[s_fold.idx];
    assign c_mag  = cear_pkg::SIN_Q15[c_fold.idx];

    // rescale magnitudes: widen, or round half up when narrowing
    generate
        if (TRIG_FRAC_BITS >= cear_pkg::Q15_BITS) begin : g_up
            assign s_scl = MW'(s_mag) << (TRIG_FRAC_BITS - cear_pkg::Q15_BITS);
            assign c_scl = MW'(c_mag) << (TRIG_FRAC_BITS - cear_pkg::Q15_BITS);
        end
        else begin : g_dn
            localparam int SH = cear_pkg::Q15_BITS - TRIG_FRAC_BITS;
            logic [16:0] s_rnd;
            logic [16:0] c_rnd;
            assign s_rnd = 17'(s_mag) + (17'd1 << (SH - 1));
            assign c_rnd = 17'(c_mag) + (17'd1 << (SH - 1));
            assign s_scl = MW'(s_rnd >> SH);
            assign c_scl = MW'(c_rnd >> SH);
        end
    endgenerate

    // apply quadrant sign
    assign s_pos   = $signed({1'b0, s_scl});
    assign c_pos   = $signed({1'b0, c_scl});
    assign sin_val = s_fold.neg ? -s_pos : s_pos;
    assign cos_val = c_fold.neg ? -c_pos : c_pos;

endmodule

### rtl/cear_rot2.sv
// ----------------------------------------------------------------------------
// cear_rot2
// Plane rotation of one point: p = R(c*a - s*b), q = R(s*a + c*b), where R
// rounds half up at TRIG_FRAC_BITS and the results wrap to 32 bits.
// ----------------------------------------------------------------------------
module cear_rot2 #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic signed [32:0]               a,
    input  logic signed [32:0]               b,
    input  logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    input  logic signed [TRIG_FRAC_BITS+1:0] cos_val,
    output logic signed [31:0]               p,
    output logic signed [31:0]               q
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PW = 33 + TW;
    localparam int SW = PW + 1;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

    logic signed [PW-1:0] ca;
    logic signed [PW-1:0] sb;
    logic signed [PW-1:0] sa;
    logic signed [PW-1:0] cb;
    logic signed [SW-1:0] p_sum;
    logic signed [SW-1:0] q_sum;
    logic signed [SW-1:0] p_shr;
    logic signed [SW-1:0] q_shr;

    // four products
    assign ca = PW'(cos_val) * PW'(a);
    assign sb = PW'(sin_val) * PW'(b);
    assign sa = PW'(sin_val) * PW'(a);
    assign cb = PW'(cos_val) * PW'(b);

    // combine and round
    assign p_sum = SW'(ca) - SW'(sb) + HALF;
    assign q_sum = SW'(sa) + SW'(cb) + HALF;
    assign p_shr = p_sum >>> TRIG_FRAC_BITS;
    assign q_shr = q_sum >>> TRIG_FRAC_BITS;

    assign p = $signed(p_shr[31:0]);
    assign q = $signed(q_shr[31:0]);

endmodule

### rtl/camera_eye_axis_rotator.sv
// ----------------------------------------------------------------------------
// camera_eye_axis_rotator
// Rotates a stored camera point and eye point about the X, Y or Z axis.
// ----------------------------------------------------------------------------
// Each command word carries an axis code and an angle in whole degrees; the
// block answers every command with one result word holding the new camera and
// eye coordinates (Q20.12, wrapping at 32 bits). Axis code three leaves the
// points as they are. The block takes one command per clock cycle for as long
// as results are taken; a command passes in turn through the command, angle,
// table and point registers. The first stage reduces the angle modulo 360, the
// second reads sine and cosine from the table, and the third rotates the stored
// points combinationally into the point registers, which is what lets each
// command use the points left by the one before it without a gap. Reset puts
// the camera at (0, -1000, 2500) and the eye at (-300, -300, -1500).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_eye_axis_rotator #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic [1:0]         func,
    input  logic signed [15:0] angle_deg,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [31:0] cam_x_out,
    output logic signed [31:0] cam_y_out,
    output logic signed [31:0] cam_z_out,
    output logic signed [31:0] eye_x_out,
    output logic signed [31:0] eye_y_out,
    output logic signed [31:0] eye_z_out
);

    localparam int TW = TRIG_FRAC_BITS + 2;

    // pipeline valid flags
    logic in_vld_reg;
    logic deg_vld_reg;
    logic trig_vld_reg;
    logic out_vld_reg;

    // pipeline payload
    cear_pkg::axis_t      in_func_reg;
    logic signed [15:0]   in_angle_reg;
    cear_pkg::axis_t      deg_func_reg;
    logic [8:0]           deg_val_reg;
    cear_pkg::axis_t      trig_func_reg;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;

    // point state, also the result word
    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [31:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic signed [31:0] cam_x_next, cam_y_next, cam_z_next;
    logic signed [31:0] eye_x_next, eye_y_next, eye_z_next;

    logic                 cmd_take;
    logic                 commit;
    logic                 trig_load;
    logic                 deg_load;
    logic [8:0]           deg_calc;
    logic signed [TW-1:0] sin_calc;
    logic signed [TW-1:0] cos_calc;

    logic signed [32:0] cx, cy, cz, ex, ey, ez, dx, dz;
    logic signed [32:0] a0, b0, a1, b1;
    logic signed [31:0] p0, q0, p1, q1;

    // handshake and stage advance
    assign commit    = trig_vld_reg && (!out_vld_reg || !res_stall);
    assign trig_load = deg_vld_reg && (!trig_vld_reg || commit);
    assign deg_load  = in_vld_reg && (!deg_vld_reg || trig_load);
    assign cmd_stall = in_vld_reg && !deg_load;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            deg_vld_reg  <= 1'b0;
            trig_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_take)
                in_vld_reg <= 1'b1;
            else if (deg_load)
                in_vld_reg <= 1'b0;
            if (deg_load)
                deg_vld_reg <= 1'b1;
            else if (trig_load)
                deg_vld_reg <= 1'b0;
            if (trig_load)
                trig_vld_reg <= 1'b1;
            else if (commit)
                trig_vld_reg <= 1'b0;
            if (commit)
                out_vld_reg <= 1'b1;
            else if (!res_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // angle reduction and table stage
    cear_angle_mod u_angle_mod (
        .angle (in_angle_reg),
        .deg   (deg_calc)
    );

    cear_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .deg     (deg_val_reg),
        .sin_val (sin_calc),
        .cos_val (cos_calc)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            in_func_reg  <= cear_pkg::axis_t'(func);
            in_angle_reg <= angle_deg;
        end
        if (deg_load)
        begin
            deg_func_reg <= in_func_reg;
            deg_val_reg  <= deg_calc;
        end
        if (trig_load)
        begin
            trig_func_reg <= deg_func_reg;
            sin_reg       <= sin_calc;
            cos_reg       <= cos_calc;
        end
    end

    // operands, widened so the eye offset stays exact
    assign cx = 33'(cam_x_reg);
    assign cy = 33'(cam_y_reg);
    assign cz = 33'(cam_z_reg);
    assign ex = 33'(eye_x_reg);
    assign ey = 33'(eye_y_reg);
    assign ez = 33'(eye_z_reg);
    assign dx = ex - cx;
    assign dz = ez - cz;

    // route each point into a plane rotator
    always_comb
    begin
        unique case (trig_func_reg)
            cear_pkg::AXIS_X:
            begin
                a0 = cy; b0 = cz; a1 = ey; b1 = ez;
            end
            cear_pkg::AXIS_Y:
            begin
                a0 = cz; b0 = cx; a1 = dx; b1 = dz;
            end
            cear_pkg::AXIS_Z:
            begin
                a0 = cx; b0 = cy; a1 = ex; b1 = ey;
            end
            cear_pkg::AXIS_NONE:
            begin
                a0 = cx; b0 = cy; a1 = ex; b1 = ey;
            end
        endcase
    end

    cear_rot2 #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_cam (
        .a       (a0),
        .b       (b0),
        .sin_val (sin_reg),
        .cos_val (cos_reg),
        .p       (p0),
        .q       (q0)
    );

    cear_rot2 #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot_eye (
        .a       (a1),
        .b       (b1),
        .sin_val (sin_reg),
        .cos_val (cos_reg),
        .p       (p1),
        .q       (q1)
    );

    // new points; the Y eye sits at the new camera plus the turned offset
    always_comb
    begin
        cam_x_next = cam_x_reg;
        cam_y_next = cam_y_reg;
        cam_z_next = cam_z_reg;
        eye_x_next = eye_x_reg;
        eye_y_next = eye_y_reg;
        eye_z_next = eye_z_reg;
        unique case (trig_func_reg)
            cear_pkg::AXIS_X:
            begin
                cam_y_next = p0;
                cam_z_next = q0;
                eye_y_next = p1;
                eye_z_next = q1;
            end
            cear_pkg::AXIS_Y:
            begin
                cam_x_next = q0;
                cam_z_next = p0;
                eye_x_next = q0 + p1;
                eye_z_next = p0 + q1;
            end
            cear_pkg::AXIS_Z:
            begin
                cam_x_next = p0;
                cam_y_next = q0;
                eye_x_next = p1;
                eye_y_next = q1;
            end
            cear_pkg::AXIS_NONE:
            begin
                cam_x_next = cam_x_reg;
            end
        endcase
    end

    // point state updates when a word moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= cear_pkg::CAM_X_RST;
            cam_y_reg <= cear_pkg::CAM_Y_RST;
            cam_z_reg <= cear_pkg::CAM_Z_RST;
            eye_x_reg <= cear_pkg::EYE_X_RST;
            eye_y_reg <= cear_pkg::EYE_Y_RST;
            eye_z_reg <= cear_pkg::EYE_Z_RST;
        end
        else if (commit)
        begin
            cam_x_reg <= cam_x_next;
            cam_y_reg <= cam_y_next;
            cam_z_reg <= cam_z_next;
            eye_x_reg <= eye_x_next;
            eye_y_reg <= eye_y_next;
            eye_z_reg <= eye_z_next;
        end
    end

    assign res_valid = out_vld_reg;
    assign cam_x_out = cam_x_reg;
    assign cam_y_out = cam_y_reg;
    assign cam_z_out = cam_z_reg;
    assign eye_x_out = eye_x_reg;
    assign eye_y_out = eye_y_reg;
    assign eye_z_out = eye_z_reg;

    // checks
    `ASSERT_NXT(a_state_only_on_commit, clk, rst_n, !commit, $stable(cam_x_reg) && $stable(cam_y_reg) && $stable(cam_z_reg) && $stable(eye_x_reg) && $stable(eye_y_reg) && $stable(eye_z_reg))
    `ASSERT_IMP(a_no_commit_when_held, clk, rst_n, out_vld_reg && res_stall, !commit)
    `ASSERT_IMP(a_stall_needs_item, clk, rst_n, cmd_stall, in_vld_reg)
    `ASSERT_NXT(a_none_keeps_state, clk, rst_n, commit && (trig_func_reg == cear_pkg::AXIS_NONE), $stable(cam_x_reg) && $stable(cam_z_reg) && $stable(eye_x_reg) && $stable(eye_z_reg))

endmodule
